// File: hdl/oale_pkg.sv
// Shared types and constants for the ordered array list engine.
`default_nettype none
package oale_pkg;

  localparam int DEPTH  = 1024;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int POS_W  = 11;
  localparam int WORD_W = 32;
  localparam int FPOS_W = 10;
  localparam int CNT_W  = 11;
  localparam int REQ_W  = 3;
  localparam int CMPW   = (CW > POS_W) ? CW : POS_W;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_EDIT   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_FIND   = 3'd5;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_BAD_INDEX,
    STAT_FULL,
    STAT_NOT_FOUND
  } status_t;

  typedef enum logic [2:0] {
    OP_APPEND,
    OP_INSERT,
    OP_EDIT,
    OP_DELETE,
    OP_READ,
    OP_FIND,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_PLACE,
    S_SHIFT_DN,
    S_READ,
    S_FIND,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] word;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] read_word;
    logic [FPOS_W-1:0]        found_position;
    logic [CNT_W-1:0]         element_count;
  } rsp_t;

  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
  } cmd_t;

endpackage
`default_nettype wire

// File: hdl/ordered_array_list_engine.sv
// Ordered list engine: intake, command FIFO and execution unit.
// Append, edit, tail insert, last-entry delete and any error go straight to the result;
// read does one store read; insert moves the entries from position up one slot, then
// places the word; delete moves the entries above position down; find walks from 0 to
// the first match or the last entry. One command executes at a time, walking the store
// one entry per cycle (one read and one write port); intake and a 2-entry FIFO hold 3 more.
// Reset clears the element count, FIFO and handshake state; store contents are not cleared.
`default_nettype none
module ordered_array_list_engine
  import oale_pkg::*;
(
  input  wire       clk,
  input  wire       rst,
  input  wire       req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire       rsp_ready,
  output rsp_t      rsp
);

  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  oale_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  oale_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_cmd    (f_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  oale_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

// File: hdl/oale_front.sv
// Request intake: registers each transfer and decodes it into a command.
`default_nettype none
module oale_front
  import oale_pkg::*;
(
  input  wire       clk,
  input  wire       rst,
  input  wire       req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      cmd_valid,
  input  wire       cmd_ready,
  output cmd_t      cmd
);

  cmd_t decoded;

  always_comb begin
    decoded.pos  = req.position;
    decoded.word = req.word;
    case (req.req_type)
      REQ_APPEND: decoded.op = OP_APPEND;
      REQ_INSERT: decoded.op = OP_INSERT;
      REQ_EDIT:   decoded.op = OP_EDIT;
      REQ_DELETE: decoded.op = OP_DELETE;
      REQ_READ:   decoded.op = OP_READ;
      REQ_FIND:   decoded.op = OP_FIND;
      default:    decoded.op = OP_NOP;
    endcase
  end

  assign req_ready = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cmd <= decoded;
    end
  end

endmodule
`default_nettype wire

// File: hdl/oale_queue.sv
// Small command FIFO between the intake and the execution unit.
`default_nettype none
module oale_queue
  import oale_pkg::*;
(
  input  wire       clk,
  input  wire       rst,
  input  wire       in_valid,
  output logic      in_ready,
  input  wire cmd_t in_cmd,
  output logic      out_valid,
  input  wire       out_ready,
  output cmd_t      out_cmd
);

  cmd_t           entries [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   fill;
  logic           push;
  logic           pop;

  assign in_ready  = (fill != (QAW + 1)'(QDEPTH));
  assign out_valid = (fill != '0);
  assign out_cmd   = entries[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QAW'(QDEPTH - 1)) ? '0 : wptr + QAW'(1);
      end
      if (pop) begin
        rptr <= (rptr == QAW'(QDEPTH - 1)) ? '0 : rptr + QAW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QAW + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QAW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= in_cmd;
    end
  end

endmodule
`default_nettype wire

// File: hdl/oale_back.sv
// Execution unit: element store, count, shift/search sequencer, result register.
`default_nettype none
module oale_back
  import oale_pkg::*;
(
  input  wire       clk,
  input  wire       rst,
  input  wire       cmd_valid,
  output logic      cmd_ready,
  input  wire cmd_t cmd,
  output logic      rsp_valid,
  input  wire       rsp_ready,
  output rsp_t      rsp
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] mem_rdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  state_t            state;
  state_t            state_next;
  cmd_t              cur;
  logic [CW-1:0]     count;
  logic [AW-1:0]     ptr;
  status_t           res_status;
  logic [WORD_W-1:0] res_word;
  logic [AW-1:0]     res_fpos;

  // decisions for the command at the queue head
  logic [CMPW-1:0] pos_c;
  logic [CMPW-1:0] cnt_c;
  logic [AW-1:0]   pos_a;
  logic [AW-1:0]   cnt_a;
  logic [CW-1:0]   cnt_m1;
  logic [AW-1:0]   cnt_m1_a;
  logic [CMPW-1:0] cur_pos_c;
  logic [AW-1:0]   cur_pos_a;
  logic            full;
  logic            pos_gt;
  logic            pos_ge;

  logic            take;
  logic            load;
  logic            cnt_inc;
  logic            cnt_dec;
  logic            ptr_load;
  logic [AW-1:0]   ptr_init;
  logic            ptr_up;
  logic            ptr_down;
  status_t         status_init;
  logic            hit;

  assign pos_c     = CMPW'(cmd.pos);
  assign cnt_c     = CMPW'(count);
  assign pos_a     = pos_c[AW-1:0];
  assign cnt_a     = count[AW-1:0];
  assign cnt_m1    = count - CW'(1);
  assign cnt_m1_a  = cnt_m1[AW-1:0];
  assign cur_pos_c = CMPW'(cur.pos);
  assign cur_pos_a = cur_pos_c[AW-1:0];
  assign full      = (count == CW'(DEPTH));
  assign pos_gt    = (pos_c > cnt_c);
  assign pos_ge    = (pos_c >= cnt_c);
  assign hit       = (mem_rdata == cur.word);
  assign load      = (state == S_DONE) && (!rsp_valid || rsp_ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_DONE;
          case (cmd.op)
            OP_INSERT: begin
              if (!pos_gt && !full && (pos_c != cnt_c)) begin
                state_next = S_SHIFT_UP;
              end
            end
            OP_DELETE: begin
              if (!pos_ge && (pos_c != cnt_c - CMPW'(1))) begin
                state_next = S_SHIFT_DN;
              end
            end
            OP_READ: begin
              if (!pos_ge) begin
                state_next = S_READ;
              end
            end
            OP_FIND: begin
              if (count != '0) begin
                state_next = S_FIND;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_SHIFT_UP: begin
        if (ptr == cur_pos_a) begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: state_next = S_DONE;
      S_SHIFT_DN: begin
        if (ptr == cnt_m1_a) begin
          state_next = S_DONE;
        end
      end
      S_READ: state_next = S_DONE;
      S_FIND: begin
        if (hit || (ptr == cnt_m1_a)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    take        = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = mem_rdata;
    cnt_inc     = 1'b0;
    cnt_dec     = 1'b0;
    ptr_load    = 1'b0;
    ptr_init    = '0;
    ptr_up      = 1'b0;
    ptr_down    = 1'b0;
    status_init = STAT_OK;
    case (state)
      S_IDLE: begin
        take = cmd_valid;
        if (cmd_valid) begin
          case (cmd.op)
            OP_APPEND: begin
              if (full) begin
                status_init = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cnt_a;
                mem_wdata = cmd.word;
                cnt_inc   = 1'b1;
              end
            end
            OP_INSERT: begin
              if (pos_gt) begin
                status_init = STAT_BAD_INDEX;
              end else if (full) begin
                status_init = STAT_FULL;
              end else if (pos_c == cnt_c) begin
                mem_we    = 1'b1;
                mem_waddr = pos_a;
                mem_wdata = cmd.word;
                cnt_inc   = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = cnt_m1_a;
                ptr_load  = 1'b1;
                ptr_init  = cnt_m1_a;
              end
            end
            OP_EDIT: begin
              if (pos_ge) begin
                status_init = STAT_BAD_INDEX;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pos_a;
                mem_wdata = cmd.word;
              end
            end
            OP_DELETE: begin
              if (pos_ge) begin
                status_init = STAT_BAD_INDEX;
              end else if (pos_c == cnt_c - CMPW'(1)) begin
                cnt_dec = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = pos_a + AW'(1);
                ptr_load  = 1'b1;
                ptr_init  = pos_a + AW'(1);
              end
            end
            OP_READ: begin
              if (pos_ge) begin
                status_init = STAT_BAD_INDEX;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = pos_a;
              end
            end
            OP_FIND: begin
              if (count == '0) begin
                status_init = STAT_NOT_FOUND;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                ptr_load  = 1'b1;
                ptr_init  = '0;
              end
            end
            default: status_init = STAT_OK;
          endcase
        end
      end
      S_SHIFT_UP: begin
        // entry read last cycle moves up one slot; read the next one down
        mem_we    = 1'b1;
        mem_waddr = ptr + AW'(1);
        if (ptr != cur_pos_a) begin
          mem_re    = 1'b1;
          mem_raddr = ptr - AW'(1);
          ptr_down  = 1'b1;
        end
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = cur_pos_a;
        mem_wdata = cur.word;
        cnt_inc   = 1'b1;
      end
      S_SHIFT_DN: begin
        mem_we    = 1'b1;
        mem_waddr = ptr - AW'(1);
        if (ptr == cnt_m1_a) begin
          cnt_dec = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr + AW'(1);
          ptr_up    = 1'b1;
        end
      end
      S_FIND: begin
        if (!hit && (ptr != cnt_m1_a)) begin
          mem_re    = 1'b1;
          mem_raddr = ptr + AW'(1);
          ptr_up    = 1'b1;
        end
      end
      default: take = 1'b0;
    endcase
  end

  assign cmd_ready = take;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cnt_inc) begin
        count <= count + CW'(1);
      end else if (cnt_dec) begin
        count <= count - CW'(1);
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur        <= cmd;
      res_status <= status_init;
      res_word   <= '0;
      res_fpos   <= '0;
    end
    if (ptr_load) begin
      ptr <= ptr_init;
    end else if (ptr_up) begin
      ptr <= ptr + AW'(1);
    end else if (ptr_down) begin
      ptr <= ptr - AW'(1);
    end
    if (state == S_READ) begin
      res_word <= mem_rdata;
    end
    if (state == S_FIND) begin
      if (hit) begin
        res_fpos <= ptr;
      end else if (ptr == cnt_m1_a) begin
        res_status <= STAT_NOT_FOUND;
      end
    end
    if (load) begin
      rsp.status         <= res_status;
      rsp.read_word      <= res_word;
      rsp.found_position <= FPOS_W'(res_fpos);
      rsp.element_count  <= CNT_W'(count);
    end
  end

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the ordered list engine: directed table and random traffic.
module tb_top;
  import oale_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;
  localparam int RAND_PER_PHASE = 100;
  localparam int TAIL_CYCLES    = DEPTH + 16;
  localparam int CYCLE_LIMIT    = 5_000_000;

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t exp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // predictor state
  logic [WORD_W-1:0] list_mem [DEPTH];
  int unsigned list_len = 0;
  int unsigned peak_len = 0;

  rsp_t expected_rsp_q [$];
  rsp_t head_rsp;
  dir_row_t dir_tab [$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int err_cnt = 0;
  int checked_cnt = 0;
  int req_cnt = 0;
  int op_seen [8];
  int unsigned cycle_cnt = 0;

  ordered_array_list_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_rsp_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic req_t mk_req(logic [REQ_W-1:0] op, int unsigned pos,
                                  logic [WORD_W-1:0] w);
    req_t r;
    r.req_type = op;
    r.position = POS_W'(pos);
    r.word     = w;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(status_t st, int unsigned cnt);
    rsp_t o;
    o = '0;
    o.status        = st;
    o.element_count = CNT_W'(cnt);
    return o;
  endfunction

  // Applies one request to the shadow list and returns the result it should produce.
  function automatic rsp_t apply_list_request(req_t r);
    rsp_t o;
    int unsigned p;
    int unsigned k;
    o = '0;
    o.status = STAT_OK;
    p = r.position;
    case (r.req_type)
      REQ_APPEND: begin
        if (list_len >= DEPTH) begin
          o.status = STAT_FULL;
        end else begin
          list_mem[list_len] = r.word;
          list_len++;
        end
      end
      REQ_INSERT: begin
        // index check wins over the full check
        if (p > list_len) begin
          o.status = STAT_BAD_INDEX;
        end else if (list_len >= DEPTH) begin
          o.status = STAT_FULL;
        end else begin
          for (k = list_len; k > p; k--) list_mem[k] = list_mem[k-1];
          list_mem[p] = r.word;
          list_len++;
        end
      end
      REQ_EDIT: begin
        if (p >= list_len) o.status = STAT_BAD_INDEX;
        else list_mem[p] = r.word;
      end
      REQ_DELETE: begin
        if (p >= list_len) begin
          o.status = STAT_BAD_INDEX;
        end else begin
          for (k = p; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
          list_len--;
        end
      end
      REQ_READ: begin
        if (p >= list_len) o.status = STAT_BAD_INDEX;
        else o.read_word = list_mem[p];
      end
      REQ_FIND: begin
        o.status = STAT_NOT_FOUND;
        for (k = 0; k < list_len; k++) begin
          if (list_mem[k] == r.word) begin
            o.status = STAT_OK;
            o.found_position = FPOS_W'(k);
            break;
          end
        end
      end
      default: begin
      end
    endcase
    o.element_count = CNT_W'(list_len);
    return o;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    if ($urandom_range(9) >= 3) return $urandom;
    // small pool so duplicates and extremes show up
    case ($urandom_range(5))
      0: return '1;
      1: return '0;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom_range(7);
    endcase
  endfunction

  // Mostly legal requests against the current list, some out-of-range and spare codes.
  function automatic req_t pick_request(int unsigned cap);
    int unsigned roll;
    int unsigned pos;
    logic [REQ_W-1:0] op;
    logic [WORD_W-1:0] w;
    roll = $urandom_range(99);
    w = pick_word();
    pos = $urandom_range(DEPTH);
    if (roll < 15) op = REQ_APPEND;
    else if (roll < 30) op = REQ_INSERT;
    else if (roll < 42) op = REQ_EDIT;
    else if (roll < 57) op = REQ_DELETE;
    else if (roll < 77) op = REQ_READ;
    else if (roll < 95) op = REQ_FIND;
    else op = $urandom_range(1) ? REQ_SPARE_6 : REQ_SPARE_7;
    if ((op == REQ_APPEND || op == REQ_INSERT) && list_len >= cap) op = REQ_DELETE;
    case (op)
      REQ_INSERT: begin
        if ($urandom_range(9) != 0) pos = $urandom_range(list_len);
        else if ($urandom_range(1)) pos = list_len + 1 + $urandom_range(3);
        else pos = DEPTH;
      end
      REQ_EDIT, REQ_DELETE, REQ_READ: begin
        if (list_len > 0 && $urandom_range(99) < 85) pos = $urandom_range(list_len - 1);
        else if ($urandom_range(1)) pos = list_len;
        else if ($urandom_range(1)) pos = DEPTH;
      end
      REQ_FIND: begin
        if (list_len > 0 && $urandom_range(9) < 7) w = list_mem[$urandom_range(list_len - 1)];
      end
      default: begin
      end
    endcase
    return mk_req(op, pos, w);
  endfunction

  task automatic send_request(input req_t r, input bit use_typed = 1'b0,
                              input rsp_t typed_rsp = '0);
    rsp_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    // transfer happened at this edge; valid is left high for the caller to reuse or drop
    pred = apply_list_request(r);
    expected_rsp_q.push_back(use_typed ? typed_rsp : pred);
    req_cnt++;
    op_seen[r.req_type]++;
    if (list_len > peak_len) peak_len = list_len;
  endtask

  task automatic wait_list_idle();
    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp_q.size() == 0) begin
        $error("unexpected result: status %0d count %0d", rsp.status, rsp.element_count);
        err_cnt++;
      end else begin
        head_rsp = expected_rsp_q.pop_front();
        checked_cnt++;
        if (rsp.status !== head_rsp.status) begin
          $error("status: expected %0d, got %0d", head_rsp.status, rsp.status);
          err_cnt++;
        end
        if (rsp.read_word !== head_rsp.read_word) begin
          $error("read_word: expected %0d, got %0d", head_rsp.read_word, rsp.read_word);
          err_cnt++;
        end
        if (rsp.found_position !== head_rsp.found_position) begin
          $error("found_position: expected %0d, got %0d", head_rsp.found_position,
                 rsp.found_position);
          err_cnt++;
        end
        if (rsp.element_count !== head_rsp.element_count) begin
          $error("element_count: expected %0d, got %0d", head_rsp.element_count,
                 rsp.element_count);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int i;
    int ph;
    foreach (op_seen[j]) op_seen[j] = 0;

    // empty list: every indexed access and every find must fail
    dir_tab.push_back('{mk_req(REQ_READ, 0, 0), 1'b1, mk_rsp(STAT_BAD_INDEX, 0)});
    dir_tab.push_back('{mk_req(REQ_EDIT, 0, 5), 1'b1, mk_rsp(STAT_BAD_INDEX, 0)});
    dir_tab.push_back('{mk_req(REQ_DELETE, 0, 0), 1'b1, mk_rsp(STAT_BAD_INDEX, 0)});
    dir_tab.push_back('{mk_req(REQ_FIND, 0, 0), 1'b1, mk_rsp(STAT_NOT_FOUND, 0)});
    dir_tab.push_back('{mk_req(REQ_INSERT, 1, 1), 1'b1, mk_rsp(STAT_BAD_INDEX, 0)});
    dir_tab.push_back('{mk_req(REQ_INSERT, DEPTH, 1), 1'b1, mk_rsp(STAT_BAD_INDEX, 0)});
    dir_tab.push_back('{mk_req(REQ_APPEND, 0, 32'h8000_0000), 1'b1, mk_rsp(STAT_OK, 1)});
    dir_tab.push_back('{mk_req(REQ_APPEND, 0, 32'h7FFF_FFFF), 1'b1, mk_rsp(STAT_OK, 2)});
    dir_tab.push_back('{mk_req(REQ_INSERT, 0, '1), 1'b1, mk_rsp(STAT_OK, 3)});
    dir_tab.push_back('{mk_req(REQ_INSERT, 3, 0), 1'b1, mk_rsp(STAT_OK, 4)});
    dir_tab.push_back('{mk_req(REQ_READ, 0, 0), 1'b0, '0});
    dir_tab.push_back('{mk_req(REQ_READ, 3, 0), 1'b0, '0});
    dir_tab.push_back('{mk_req(REQ_READ, 4, 0), 1'b1, mk_rsp(STAT_BAD_INDEX, 4)});
    dir_tab.push_back('{mk_req(REQ_READ, DEPTH, 0), 1'b1, mk_rsp(STAT_BAD_INDEX, 4)});
    dir_tab.push_back('{mk_req(REQ_FIND, 0, 32'h7FFF_FFFF), 1'b0, '0});
    dir_tab.push_back('{mk_req(REQ_FIND, 0, 32'h1234_5678), 1'b1, mk_rsp(STAT_NOT_FOUND, 4)});
    // duplicate value: find must report the lower index
    dir_tab.push_back('{mk_req(REQ_EDIT, 1, 32'h7FFF_FFFF), 1'b0, '0});
    dir_tab.push_back('{mk_req(REQ_FIND, 0, 32'h7FFF_FFFF), 1'b0, '0});
    dir_tab.push_back('{mk_req(REQ_EDIT, 4, 9), 1'b1, mk_rsp(STAT_BAD_INDEX, 4)});
    dir_tab.push_back('{mk_req(REQ_DELETE, 1, 0), 1'b0, '0});
    dir_tab.push_back('{mk_req(REQ_DELETE, 3, 0), 1'b1, mk_rsp(STAT_BAD_INDEX, 3)});
    dir_tab.push_back('{mk_req(REQ_SPARE_6, 0, 0), 1'b1, mk_rsp(STAT_OK, 3)});
    dir_tab.push_back('{mk_req(REQ_SPARE_7, DEPTH - 1, '1), 1'b1, mk_rsp(STAT_OK, 3)});
    dir_tab.push_back('{mk_req(REQ_DELETE, 2, 0), 1'b0, '0});
    dir_tab.push_back('{mk_req(REQ_READ, 0, 0), 1'b0, '0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[k]) send_request(dir_tab[k].r, dir_tab[k].typed, dir_tab[k].exp);
    wait_list_idle();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 59; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 59; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      for (i = 0; i < RAND_PER_PHASE; i++) begin
        // hold the sender off until every result is back
        if (ph == 1 && i == RAND_PER_PHASE / 2) wait_list_idle();
        send_request(pick_request(ph == 3 ? 200 : 48));
      end
      wait_list_idle();
    end

    // every expected result is back; give the block time to show any stray output
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_rsp_q.size() != 0) begin
      $error("%0d results never arrived", expected_rsp_q.size());
      err_cnt++;
    end

    $display("Sent %0d requests: append %0d, insert %0d, edit %0d, delete %0d, read %0d,",
             req_cnt, op_seen[REQ_APPEND], op_seen[REQ_INSERT], op_seen[REQ_EDIT],
             op_seen[REQ_DELETE], op_seen[REQ_READ]);
    $display("  find %0d, spare %0d; %0d results checked, list peaked at %0d of %0d",
             op_seen[REQ_FIND], op_seen[REQ_SPARE_6] + op_seen[REQ_SPARE_7], checked_cnt,
             peak_len, DEPTH);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: ordered_array_list_engine.f
hdl/oale_pkg.sv
hdl/oale_front.sv
hdl/oale_queue.sv
hdl/oale_back.sv
hdl/ordered_array_list_engine.sv
test/tb_top.sv
